/* src/tsbe_pkg.sv */
// Shared constants, types and key-square lookup functions for the two-square bigram encryptor.
package tsbe_pkg;

    localparam int GAP_DEPTH_DEF = 32;
    localparam int SQ_SIDE       = 5;
    localparam int SQ_CELLS      = 25;

    localparam logic [7:0] LETTER_A = 8'h61;
    localparam logic [7:0] LETTER_Z = 8'h7a;
    localparam logic [7:0] LETTER_Q = 8'd113;

    localparam logic [7:0] SQ_ONE [SQ_CELLS] = '{
        "e", "n", "c", "r", "y",
        "p", "t", "a", "b", "d",
        "f", "g", "h", "i", "j",
        "k", "l", "m", "o", "s",
        "u", "v", "w", "x", "z"
    };

    localparam logic [7:0] SQ_TWO [SQ_CELLS] = '{
        "w", "o", "r", "d", "s",
        "a", "b", "c", "e", "f",
        "g", "h", "i", "j", "k",
        "l", "m", "n", "p", "t",
        "u", "v", "x", "y", "z"
    };

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } rc_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIRST = 5'b00010,
        S_READ  = 5'b00100,
        S_GAP   = 5'b01000,
        S_TAIL  = 5'b10000
    } seq_state_t;

    function automatic logic is_pair_letter(input logic [7:0] b);
        return (b inside {[LETTER_A:LETTER_Z]}) && (b != LETTER_Q);
    endfunction

    // Parallel compare over all cells; each pair letter sits in exactly one cell.
    function automatic rc_t find_cell(input logic sel_two, input logic [7:0] b);
        rc_t        res;
        logic [7:0] cell_val;
        res = '0;
        for (int r = 0; r < SQ_SIDE; r++)
        begin
            for (int c = 0; c < SQ_SIDE; c++)
            begin
                cell_val = sel_two ? SQ_TWO[r * SQ_SIDE + c] : SQ_ONE[r * SQ_SIDE + c];
                if (cell_val == b)
                begin
                    res.row = 3'(r);
                    res.col = 3'(c);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] cell_at(input logic sel_two, input rc_t rc);
        logic [4:0] idx;
        logic [7:0] val;
        idx = ({2'b00, rc.row} << 2) + {2'b00, rc.row} + {2'b00, rc.col};
        val = '0;
        for (int i = 0; i < SQ_CELLS; i++)
        begin
            if (idx == 5'(i))
            begin
                val = sel_two ? SQ_TWO[i] : SQ_ONE[i];
            end
        end
        return val;
    endfunction

endpackage

/* src/two_square_bigram_encryptor.sv */
// An item that produces results is captured on acceptance; the FIRST state then loads its first
// result into the output register once the slot is free. A held or buffered byte leaves the
// sequencer idle; each gap byte goes through the gap memory's single registered read.
// in_stall stays high until the last result of the item has been loaded into the output register.
// Reset clears the held letter, the gap count, the sequencer and the output valid flag;
// the gap memory is not cleared and is read only below the gap count.
module two_square_bigram_encryptor
    import tsbe_pkg::*;
#(
    parameter int GAP_DEPTH = GAP_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       text_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       gap_overflow
);

    localparam int CW = $clog2(GAP_DEPTH + 1);
    localparam int AW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;

    seq_state_t state_reg, state_next;

    logic          held_valid_reg, held_valid_next;
    logic [7:0]    held_letter_reg, held_letter_next;
    rc_t           held_rc_reg, held_rc_next;
    logic [CW-1:0] gap_cnt_reg, gap_cnt_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]    first_byte_reg, first_byte_next;
    logic          first_flag_reg, first_flag_next;
    logic [7:0]    tail_byte_reg, tail_byte_next;
    logic          tail_en_reg, tail_en_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          run_last_reg, run_last_next;
    logic          gap_ovf_reg, gap_ovf_next;

    logic [7:0]    gap_mem [GAP_DEPTH];
    logic [7:0]    rd_data_reg;

    logic          in_accept;
    logic          slot_free;
    logic          letter;
    logic          gap_full;
    logic          mem_we;
    logic          gap_done;
    rc_t           rc2;
    logic [7:0]    cipher_x;
    logic [7:0]    cipher_y;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign letter    = is_pair_letter(in_byte);
    assign gap_full  = (gap_cnt_reg == CW'(GAP_DEPTH));
    assign mem_we    = in_accept && held_valid_reg && !letter && !gap_full;
    assign gap_done  = ((rd_idx_reg + 1'b1) == gap_cnt_reg);

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign run_last     = run_last_reg;
    assign gap_overflow = gap_ovf_reg;

    // Column rule: shared column swaps rows, otherwise swap columns.
    always_comb
    begin
        rc2 = find_cell(1'b1, in_byte);
        if (held_rc_reg.col == rc2.col)
        begin
            cipher_x = cell_at(1'b0, '{row: rc2.row, col: held_rc_reg.col});
            cipher_y = cell_at(1'b1, '{row: held_rc_reg.row, col: held_rc_reg.col});
        end
        else
        begin
            cipher_x = cell_at(1'b0, '{row: held_rc_reg.row, col: rc2.col});
            cipher_y = cell_at(1'b1, '{row: rc2.row, col: held_rc_reg.col});
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        held_rc_next     = held_rc_reg;
        gap_cnt_next     = gap_cnt_reg;
        rd_idx_next      = rd_idx_reg;
        first_byte_next  = first_byte_reg;
        first_flag_next  = first_flag_reg;
        tail_byte_next   = tail_byte_reg;
        tail_en_next     = tail_en_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_byte_next    = out_byte_reg;
        run_last_next    = run_last_reg;
        gap_ovf_next     = gap_ovf_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    rd_idx_next     = '0;
                    first_flag_next = 1'b0;
                    tail_en_next    = 1'b0;
                    tail_byte_next  = in_byte;
                    if (!held_valid_reg)
                    begin
                        if (letter && !text_end)
                        begin
                            held_valid_next  = 1'b1;
                            held_letter_next = in_byte;
                            held_rc_next     = find_cell(1'b0, in_byte);
                            gap_cnt_next     = '0;
                        end
                        else
                        begin
                            first_byte_next = in_byte;
                            state_next      = S_FIRST;
                        end
                    end
                    else if (letter)
                    begin
                        first_byte_next = cipher_x;
                        tail_byte_next  = cipher_y;
                        tail_en_next    = 1'b1;
                        held_valid_next = 1'b0;
                        state_next      = S_FIRST;
                    end
                    else if (!gap_full)
                    begin
                        gap_cnt_next = gap_cnt_reg + 1'b1;
                        if (text_end)
                        begin
                            first_byte_next = held_letter_reg;
                            held_valid_next = 1'b0;
                            state_next      = S_FIRST;
                        end
                    end
                    else
                    begin
                        // Store full: release the held letter unpaired.
                        first_byte_next = held_letter_reg;
                        first_flag_next = 1'b1;
                        tail_en_next    = 1'b1;
                        held_valid_next = 1'b0;
                        state_next      = S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = first_byte_reg;
                    gap_ovf_next   = first_flag_reg;
                    run_last_next  = (gap_cnt_reg == '0) && !tail_en_reg;
                    if (gap_cnt_reg != '0)
                    begin
                        state_next = S_READ;
                    end
                    else if (tail_en_reg)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_GAP;
            end
            S_GAP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data_reg;
                    gap_ovf_next   = 1'b0;
                    run_last_next  = gap_done && !tail_en_reg;
                    rd_idx_next    = rd_idx_reg + 1'b1;
                    if (!gap_done)
                    begin
                        state_next = S_READ;
                    end
                    else if (tail_en_reg)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        gap_cnt_next = '0;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_TAIL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = tail_byte_reg;
                    gap_ovf_next   = 1'b0;
                    run_last_next  = 1'b1;
                    gap_cnt_next   = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            held_valid_reg  <= 1'b0;
            held_letter_reg <= '0;
            gap_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
            gap_cnt_reg     <= gap_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_rc_reg    <= held_rc_next;
        rd_idx_reg     <= rd_idx_next;
        first_byte_reg <= first_byte_next;
        first_flag_reg <= first_flag_next;
        tail_byte_reg  <= tail_byte_next;
        tail_en_reg    <= tail_en_next;
        out_byte_reg   <= out_byte_next;
        run_last_reg   <= run_last_next;
        gap_ovf_reg    <= gap_ovf_next;
    end

    // Gap memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            gap_mem[gap_cnt_reg[AW-1:0]] <= in_byte;
        end
        rd_data_reg <= gap_mem[rd_idx_reg[AW-1:0]];
    end

    a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gap_cnt_reg <= CW'(GAP_DEPTH))
        else $error("gap count beyond store depth");

    a_gap_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_GAP) |-> (gap_cnt_reg != '0))
        else $error("gap drain with empty store");

    a_pair_release: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && held_valid_reg && letter) |=> (state_reg == S_FIRST && !held_valid_reg))
        else $error("completed pair did not release held letter");

    a_ovf_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && gap_ovf_reg) |-> !run_last_reg)
        else $error("overflow flush marked as final transaction");

endmodule

/* bench/two_square_bigram_encryptor_test.sv */
// Self-checking testbench for the two-square bigram encryptor.
module two_square_bigram_encryptor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tsbe_pkg::*;

    localparam int GAP_LIMIT    = GAP_DEPTH_DEF;
    localparam int KEY_SIDE     = 5;
    localparam int KEY_CELLS    = 25;
    localparam int QUIET_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_Z       = 8'h7a;
    localparam logic [7:0] CH_Q       = 8'h71;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    // Key squares, row major: index 0 is the first square, index 1 the second.
    localparam logic [7:0] KEY_SQ [2][KEY_CELLS] = '{
        '{"e", "n", "c", "r", "y", "p", "t", "a", "b", "d", "f", "g", "h",
          "i", "j", "k", "l", "m", "o", "s", "u", "v", "w", "x", "z"},
        '{"w", "o", "r", "d", "s", "a", "b", "c", "e", "f", "g", "h", "i",
          "j", "k", "l", "m", "n", "p", "t", "u", "v", "x", "y", "z"}
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last_mark;
        logic       flushed;
    } cipher_out_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       text_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       run_last;
    logic       gap_overflow;

    // Predictor state
    logic       letter_held;
    logic [7:0] held_ch;
    logic [7:0] gap_bytes [$];

    cipher_out_t pending_cipher [$];

    bit idle_on;
    int err_count;
    int bytes_sent;
    int bytes_checked;
    int flushes_seen;
    int ends_sent;
    int quiet_cycles;
    int out_hold;

    two_square_bigram_encryptor dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .text_end     (text_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .gap_overflow (gap_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic is_plain_letter(input logic [7:0] b);
        return (b inside {[CH_A:CH_Z]}) && (b != CH_Q);
    endfunction

    function automatic int key_cell(input int sq, input logic [7:0] b);
        for (int i = 0; i < KEY_CELLS; i++)
        begin
            if (KEY_SQ[sq][i] == b)
                return i;
        end
        return 0;
    endfunction

    // Advance the predictor by one accepted byte and queue what it emits.
    function automatic void encode_step(input logic [7:0] b, input logic fin);
        cipher_out_t outs [$];
        int          r1, c1, r2, c2;
        logic [7:0]  x, y;
        if (!letter_held)
        begin
            if (is_plain_letter(b) && !fin)
            begin
                letter_held = 1'b1;
                held_ch = b;
                gap_bytes.delete();
                return;
            end
            outs.push_back('{b, 1'b0, 1'b0});
        end
        else if (is_plain_letter(b))
        begin
            r1 = key_cell(0, held_ch) / KEY_SIDE;
            c1 = key_cell(0, held_ch) % KEY_SIDE;
            r2 = key_cell(1, b) / KEY_SIDE;
            c2 = key_cell(1, b) % KEY_SIDE;
            if (c1 == c2)
            begin
                x = KEY_SQ[0][r2 * KEY_SIDE + c1];
                y = KEY_SQ[1][r1 * KEY_SIDE + c1];
            end
            else
            begin
                x = KEY_SQ[0][r1 * KEY_SIDE + c2];
                y = KEY_SQ[1][r2 * KEY_SIDE + c1];
            end
            outs.push_back('{x, 1'b0, 1'b0});
            foreach (gap_bytes[i])
                outs.push_back('{gap_bytes[i], 1'b0, 1'b0});
            outs.push_back('{y, 1'b0, 1'b0});
            letter_held = 1'b0;
            gap_bytes.delete();
        end
        else if (gap_bytes.size() < GAP_LIMIT)
        begin
            gap_bytes.push_back(b);
            if (fin)
            begin
                outs.push_back('{held_ch, 1'b0, 1'b0});
                foreach (gap_bytes[i])
                    outs.push_back('{gap_bytes[i], 1'b0, 1'b0});
            end
        end
        else
        begin
            // Gap store full: release the held letter unpaired.
            outs.push_back('{held_ch, 1'b0, 1'b1});
            foreach (gap_bytes[i])
                outs.push_back('{gap_bytes[i], 1'b0, 1'b0});
            outs.push_back('{b, 1'b0, 1'b0});
            letter_held = 1'b0;
            gap_bytes.delete();
        end
        if (fin)
        begin
            letter_held = 1'b0;
            gap_bytes.delete();
        end
        if (outs.size() > 0)
            outs[outs.size() - 1].last_mark = 1'b1;
        foreach (outs[i])
            pending_cipher.push_back(outs[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = CH_A + 8'($urandom_range(0, 24));
        if (c >= CH_Q)
            c = c + 8'd1;
        return c;
    endfunction

    // Mostly separators, some raw bytes that may well be letters.
    function automatic logic [7:0] rand_gap_byte(input bit strict);
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: c = CH_SPACE;
            1: c = CH_NEWLINE;
            2: c = CH_ZERO + 8'($urandom_range(0, 9));
            3: c = CH_Q;
            default: c = 8'($urandom_range(0, 255));
        endcase
        if (strict && is_plain_letter(c))
            c = CH_Q;
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte = b;
        text_end = fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        encode_step(b, fin);
        bytes_sent++;
        if (fin)
            ends_sent++;
        @(negedge clk);
    endtask

    task automatic test_directed_cases();
        idle_on = 1'b1;
        send_byte(CH_A, 1'b0);
        send_byte(CH_Z, 1'b0);
        // same column in both squares
        send_byte("e", 1'b0);
        send_byte("w", 1'b0);
        // pair split by pass-through bytes of several kinds
        send_byte("b", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_Q, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h60, 1'b0);
        send_byte(8'h7b, 1'b0);
        send_byte("A", 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte("c", 1'b0);
        // letter with nothing held at end of text goes out as is
        send_byte(CH_Z, 1'b1);
        // end of text on a gap byte flushes the held letter
        send_byte("p", 1'b0);
        send_byte("5", 1'b1);
        // end of text on the second letter still pairs
        send_byte("k", 1'b0);
        send_byte("y", 1'b1);
        send_byte(CH_SPACE, 1'b1);
        send_byte("m", 1'b0);
        send_byte("h", 1'b0);
    endtask

    task automatic test_gap_overflow();
        idle_on = 1'b1;
        // full gap store, then the closing letter: the longest burst of results
        send_byte(rand_letter(), 1'b0);
        repeat (GAP_LIMIT) send_byte(rand_gap_byte(1'b1), 1'b0);
        send_byte(rand_letter(), 1'b0);
        // one gap byte too many
        send_byte(rand_letter(), 1'b0);
        repeat (GAP_LIMIT) send_byte(rand_gap_byte(1'b1), 1'b0);
        send_byte(rand_gap_byte(1'b1), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_text(input int count, input bit with_idle);
        int n;
        int gap_len;
        n = 0;
        while (n < count)
        begin
            idle_on = with_idle && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 8))
            begin
                send_byte(rand_letter(), 1'($urandom_range(0, 29) == 0));
                n++;
            end
            gap_len = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 34)
                                                   : $urandom_range(0, 3);
            repeat (gap_len)
            begin
                send_byte(rand_gap_byte(1'b0), 1'($urandom_range(0, 29) == 0));
                n++;
            end
        end
    endtask

    task automatic test_random_text();
        random_text(100, 1'b1);
    endtask

    task automatic test_streaming_text();
        random_text(30, 1'b0);
    endtask

    // Receiver back-pressure in bursts
    initial
    begin
        out_stall = 1'b0;
        out_hold = 0;
        forever
        begin
            @(negedge clk);
            if (out_hold > 0)
                out_hold--;
            else if (idle_on && $urandom_range(0, 9) == 0)
                out_hold = $urandom_range(1, 18);
            out_stall = idle_on && (out_hold > 0);
        end
    end

    // Compare each output transaction with the oldest expected byte.
    always @(posedge clk)
    begin
        cipher_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            bytes_checked++;
            if (gap_overflow)
                flushes_seen++;
            if (pending_cipher.size() == 0)
            begin
                $error("unexpected output byte %h", out_byte);
                err_count++;
            end
            else
            begin
                want = pending_cipher.pop_front();
                if (out_byte !== want.ch)
                begin
                    $error("out_byte: expected %h, got %h", want.ch, out_byte);
                    err_count++;
                end
                if (run_last !== want.last_mark)
                begin
                    $error("run_last: expected %b, got %b", want.last_mark, run_last);
                    err_count++;
                end
                if (gap_overflow !== want.flushed)
                begin
                    $error("gap_overflow: expected %b, got %b", want.flushed, gap_overflow);
                    err_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", quiet_cycles);
            $display("FAIL two_square_bigram_encryptor");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'h00;
        text_end = 1'b0;
        idle_on = 1'b0;
        letter_held = 1'b0;
        held_ch = 8'h00;
        err_count = 0;
        bytes_sent = 0;
        bytes_checked = 0;
        flushes_seen = 0;
        ends_sent = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_gap_overflow();
        test_random_text();
        test_streaming_text();

        in_valid = 1'b0;
        while (pending_cipher.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d text bytes (%0d text ends), checked %0d cipher bytes,",
                 bytes_sent, ends_sent, bytes_checked);
        $display("%0d of them unpaired letters flushed by a full gap store", flushes_seen);
        if (err_count == 0)
            $display("PASS two_square_bigram_encryptor");
        else
            $display("FAIL two_square_bigram_encryptor");
        $finish;
    end

endmodule
